// File: rtl/twcg_pkg.sv
// ----------------------------------------------------------------------------
// twcg_pkg
// Shared types, constants and tables of the traveling wave curve generator.
// ----------------------------------------------------------------------------
`default_nettype none

package twcg_pkg;

   localparam int MAX_POINTS_DEF   = 64;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int XW = 56;
   localparam int ZW = 36;

   localparam logic [29:0] K_Q30 = 30'd652032874;

   typedef logic signed [XW-1:0] cx_type;
   typedef logic signed [ZW-1:0] cz_type;

   typedef enum logic [2:0] {
      REG_POINT_COUNT  = 3'd0,
      REG_SEGMENT_LEN  = 3'd1,
      REG_PHASE_STEP   = 3'd2,
      REG_SPATIAL_STEP = 3'd3,
      REG_WAVE_GAIN    = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_SIN,
      OP_MUL,
      OP_VEC,
      OP_ANG,
      OP_NORM,
      OP_LOAD,
      OP_SEG,
      OP_ACC
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        first;
      logic        last;
      logic [5:0]  idx;
   } cmd_type;

   typedef struct packed {
      logic        cdone;
      logic        out_free;
      logic [6:0]  total;
   } status_type;

   function automatic logic [29:0] atan_val(input logic [4:0] k);
      logic [29:0] v;
      case (k)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: rtl/traveling_wave_curve_generator_unit.sv
// ----------------------------------------------------------------------------
// traveling_wave_curve_generator_unit
// Emits one polyline with normals per tick of a sine-driven traveling wave.
// ----------------------------------------------------------------------------
//  channel  ports                     meaning
//  req      req_valid/req_stall       one tick, advance flag
//  rsp      rsp_valid/rsp_stall       one point per transaction
//  csr      csr_wr_en/index/wr_data   register write, no wait
//
// Each point runs the shared iterative CORDIC in up to four passes: sine,
// arctangent, normal and segment; the last point runs only the normal pass.
// A new tick is taken once the last point sits in the result register.
// Reset is synchronous and restores the register defaults and zero phase.
// A stalled result holds the sequencer at the emit step.
`default_nettype none

module traveling_wave_curve_generator_unit #(
   parameter int MAX_POINTS   = twcg_pkg::MAX_POINTS_DEF,
   parameter int CORDIC_STEPS = twcg_pkg::CORDIC_STEPS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_wr_en,
   input  wire  [2:0]          csr_index,
   input  wire  [19:0]         csr_wr_data,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire                 req_advance,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [5:0]          rsp_point_index,
   output logic signed [31:0]  rsp_pos_x,
   output logic signed [31:0]  rsp_pos_y,
   output logic signed [15:0]  rsp_norm_x,
   output logic signed [15:0]  rsp_norm_y,
   output logic                rsp_final_point
);

   twcg_pkg::cmd_type    cmd;
   twcg_pkg::status_type status;

   twcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   twcg_datapath #(
      .MAX_POINTS   (MAX_POINTS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_advance     (req_advance),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_index (rsp_point_index),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_norm_x      (rsp_norm_x),
      .rsp_norm_y      (rsp_norm_y),
      .rsp_final_point (rsp_final_point)
   );

endmodule

`default_nettype wire

// File: rtl/twcg_cordic.sv
// ----------------------------------------------------------------------------
// twcg_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
`default_nettype none

module twcg_cordic #(
   parameter int CORDIC_STEPS = twcg_pkg::CORDIC_STEPS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire                  vec_mode,
   input  twcg_pkg::cx_type     x0,
   input  twcg_pkg::cx_type     y0,
   input  twcg_pkg::cz_type     z0,
   output logic                 done,
   output twcg_pkg::cx_type     x_out,
   output twcg_pkg::cx_type     y_out,
   output twcg_pkg::cz_type     z_out
);

   localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [SW-1:0] LAST = SW'(CORDIC_STEPS - 1);

   twcg_pkg::cx_type x_ff, y_ff, xs, ys;
   twcg_pkg::cz_type z_ff, at;
   logic [SW-1:0]    k_ff;
   logic             busy_ff, done_ff, vec_ff, d;

   always_comb begin
      xs = x_ff >>> k_ff;
      ys = y_ff >>> k_ff;
      at = {6'd0, twcg_pkg::atan_val(5'(k_ff))};
      d  = vec_ff ? y_ff[twcg_pkg::XW-1] : ~z_ff[twcg_pkg::ZW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
         end else if (busy_ff) begin
            k_ff <= k_ff + 1'b1;
            if (k_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x0;
         y_ff   <= y0;
         z_ff   <= z0;
         vec_ff <= vec_mode;
      end else if (busy_ff) begin
         if (d) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
      end
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

`default_nettype wire

// File: rtl/twcg_datapath.sv
// ----------------------------------------------------------------------------
// twcg_datapath
// Registers, phase and position accumulators, multipliers, CORDIC and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module twcg_datapath #(
   parameter int MAX_POINTS   = twcg_pkg::MAX_POINTS_DEF,
   parameter int CORDIC_STEPS = twcg_pkg::CORDIC_STEPS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_wr_en,
   input  wire  [2:0]           csr_index,
   input  wire  [19:0]          csr_wr_data,
   input  wire                  req_advance,
   input  twcg_pkg::cmd_type    cmd,
   output twcg_pkg::status_type status,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [5:0]           rsp_point_index,
   output logic signed [31:0]   rsp_pos_x,
   output logic signed [31:0]   rsp_pos_y,
   output logic signed [15:0]   rsp_norm_x,
   output logic signed [15:0]   rsp_norm_y,
   output logic                 rsp_final_point
);

   localparam int LIM_RAW = (MAX_POINTS < 64) ? MAX_POINTS : 64;
   localparam int LIM     = (LIM_RAW < 2) ? 2 : LIM_RAW;
   localparam logic [6:0] LIM7 = 7'(LIM);

   logic [6:0]  point_count_ff;
   logic [19:0] segment_len_ff;
   logic [15:0] phase_step_ff, spatial_step_ff, wave_gain_ff;
   logic [15:0] wave_phase_ff, wave_phase_in, pt_phase_ff;
   logic [31:0] work_x_ff, work_y_ff;
   logic [15:0] prior_ff, right_ff;
   logic        neg_ff;
   twcg_pkg::cx_type tan_ff;

   logic        c_start, c_vec, c_done, fold_neg;
   twcg_pkg::cx_type c_x0, c_y0, c_x, c_y;
   twcg_pkg::cz_type c_z0, c_z, zr;
   logic [15:0] fold_p;
   logic signed [32:0] sine_s;
   logic signed [49:0] prod;
   logic [49:0] kl;
   logic [16:0] bis;
   logic signed [19:0] ang20;
   logic [15:0] ang16;
   twcg_pkg::cx_type rx, ry;
   logic signed [15:0] nx, ny;
   logic [6:0]  total;

   always_comb begin
      if (point_count_ff < 7'd2)     total = 7'd2;
      else if (point_count_ff > LIM7) total = LIM7;
      else                            total = point_count_ff;
   end

   assign wave_phase_in = req_advance ? wave_phase_ff + phase_step_ff : wave_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff  <= 7'd40;
         segment_len_ff  <= 20'd4202;
         phase_step_ff   <= 16'd1043;
         spatial_step_ff <= 16'd671;
         wave_gain_ff    <= 16'd3217;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            twcg_pkg::REG_POINT_COUNT:  point_count_ff  <= csr_wr_data[6:0];
            twcg_pkg::REG_SEGMENT_LEN:  segment_len_ff  <= csr_wr_data;
            twcg_pkg::REG_PHASE_STEP:   phase_step_ff   <= csr_wr_data[15:0];
            twcg_pkg::REG_SPATIAL_STEP: spatial_step_ff <= csr_wr_data[15:0];
            twcg_pkg::REG_WAVE_GAIN:    wave_gain_ff    <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   // sine argument folding
   assign fold_neg = (pt_phase_ff[15:14] == 2'd1) || (pt_phase_ff[15:14] == 2'd2);
   assign fold_p   = fold_neg ? (pt_phase_ff ^ 16'h8000) : pt_phase_ff;

   assign sine_s = neg_ff ? -c_y[32:0] : c_y[32:0];
   assign prod   = sine_s * $signed({1'b0, wave_gain_ff});
   assign kl     = 50'(twcg_pkg::K_Q30) * 50'(segment_len_ff);
   assign bis    = {prior_ff[15], prior_ff} + {right_ff[15], right_ff};

   assign zr    = c_z + twcg_pkg::cz_type'(36'sd32768);
   assign ang20 = zr[35:16];
   always_comb begin
      if (ang20 > 20'sd16384)       ang16 = 16'sd16384;
      else if (ang20 < -20'sd16384) ang16 = -16'sd16384;
      else                          ang16 = ang20[15:0];
   end

   assign rx = c_x + twcg_pkg::cx_type'(56'sd536870912);
   assign ry = c_y + twcg_pkg::cx_type'(56'sd536870912);

   // round to Q1.14 and clamp
   always_comb begin
      logic signed [39:0] tx, ty;
      tx = 40'((c_x + twcg_pkg::cx_type'(56'sd32768)) >>> 16);
      ty = 40'((c_y + twcg_pkg::cx_type'(56'sd32768)) >>> 16);
      if (tx > 40'sd16384)       ny = 16'sd16384;
      else if (tx < -40'sd16384) ny = -16'sd16384;
      else                       ny = tx[15:0];
      if (ty > 40'sd16384)       nx = -16'sd16384;
      else if (ty < -40'sd16384) nx = 16'sd16384;
      else                       nx = -ty[15:0];
   end

   always_comb begin
      c_start = 1'b0;
      c_vec   = 1'b0;
      c_x0    = '0;
      c_y0    = '0;
      c_z0    = '0;
      case (cmd.op)
         twcg_pkg::OP_SIN: begin
            c_start = 1'b1;
            c_x0    = twcg_pkg::cx_type'({26'd0, twcg_pkg::K_Q30});
            c_z0    = {{4{fold_p[15]}}, fold_p, 16'd0};
         end
         twcg_pkg::OP_VEC: begin
            c_start = 1'b1;
            c_vec   = 1'b1;
            c_x0    = twcg_pkg::cx_type'(56'sd1073741824);
            c_y0    = tan_ff;
         end
         twcg_pkg::OP_NORM: begin
            c_start = 1'b1;
            c_x0    = twcg_pkg::cx_type'({26'd0, twcg_pkg::K_Q30});
            if (cmd.first)     c_z0 = {{4{right_ff[15]}}, right_ff, 16'd0};
            else if (cmd.last) c_z0 = {{4{prior_ff[15]}}, prior_ff, 16'd0};
            else               c_z0 = {{4{bis[16]}}, bis, 15'd0};
         end
         twcg_pkg::OP_SEG: begin
            c_start = 1'b1;
            c_x0    = {6'd0, kl};
            c_z0    = {{4{right_ff[15]}}, right_ff, 16'd0};
         end
         default: ;
      endcase
   end

   twcg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .start    (c_start),
      .vec_mode (c_vec),
      .x0       (c_x0),
      .y0       (c_y0),
      .z0       (c_z0),
      .done     (c_done),
      .x_out    (c_x),
      .y_out    (c_y),
      .z_out    (c_z)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_phase_ff <= '0;
         work_x_ff     <= '0;
         work_y_ff     <= '0;
         prior_ff      <= '0;
         rsp_valid     <= 1'b0;
      end else begin
         if (cmd.op == twcg_pkg::OP_LOAD) rsp_valid <= 1'b1;
         else if (!rsp_stall)             rsp_valid <= 1'b0;
         case (cmd.op)
            twcg_pkg::OP_START: begin
               wave_phase_ff <= wave_phase_in;
               pt_phase_ff   <= wave_phase_in - spatial_step_ff;
               work_x_ff     <= '0;
               work_y_ff     <= '0;
            end
            twcg_pkg::OP_SIN: neg_ff <= fold_neg;
            twcg_pkg::OP_MUL: tan_ff <= twcg_pkg::cx_type'(prod >>> 12);
            twcg_pkg::OP_ANG: right_ff <= ang16;
            twcg_pkg::OP_ACC: begin
               work_x_ff   <= work_x_ff + {{6{rx[55]}}, rx[55:30]};
               work_y_ff   <= work_y_ff + {{6{ry[55]}}, ry[55:30]};
               prior_ff    <= right_ff;
               pt_phase_ff <= pt_phase_ff - spatial_step_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == twcg_pkg::OP_LOAD) begin
         rsp_point_index <= cmd.idx;
         rsp_pos_x       <= work_x_ff;
         rsp_pos_y       <= work_y_ff;
         rsp_norm_x      <= nx;
         rsp_norm_y      <= ny;
         rsp_final_point <= cmd.last;
      end
   end

   assign status = {c_done, ~rsp_valid | ~rsp_stall, total};

endmodule

`default_nettype wire

// File: rtl/twcg_ctrl.sv
// ----------------------------------------------------------------------------
// twcg_ctrl
// Sequencer: per point, sine, gain, arctangent, normal, emit, segment, accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module twcg_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  twcg_pkg::status_type status,
   output twcg_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_SIN, S_SINW, S_MUL, S_VEC, S_VECW, S_ANG,
      S_NORM, S_NORMW, S_LOAD, S_SEG, S_SEGW, S_ACC
   } state_type;

   state_type  state_ff;
   logic [6:0] idx_ff;
   logic       last;

   assign last = (idx_ff + 7'd1) == status.total;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE:  if (req_valid) begin
               idx_ff   <= '0;
               state_ff <= S_SIN;
            end
            S_SIN:   state_ff <= S_SINW;
            S_SINW:  if (status.cdone) state_ff <= S_MUL;
            S_MUL:   state_ff <= S_VEC;
            S_VEC:   state_ff <= S_VECW;
            S_VECW:  if (status.cdone) state_ff <= S_ANG;
            S_ANG:   state_ff <= S_NORM;
            S_NORM:  state_ff <= S_NORMW;
            S_NORMW: if (status.cdone) state_ff <= S_LOAD;
            S_LOAD:  if (status.out_free) state_ff <= last ? S_IDLE : S_SEG;
            S_SEG:   state_ff <= S_SEGW;
            S_SEGW:  if (status.cdone) state_ff <= S_ACC;
            S_ACC: begin
               idx_ff   <= idx_ff + 7'd1;
               state_ff <= ((idx_ff + 7'd2) == status.total) ? S_NORM : S_SIN;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.op    = twcg_pkg::OP_NONE;
      cmd.first = (idx_ff == 7'd0);
      cmd.last  = last;
      cmd.idx   = idx_ff[5:0];
      unique case (state_ff)
         S_IDLE: if (req_valid) cmd.op = twcg_pkg::OP_START;
         S_SIN:  cmd.op = twcg_pkg::OP_SIN;
         S_MUL:  cmd.op = twcg_pkg::OP_MUL;
         S_VEC:  cmd.op = twcg_pkg::OP_VEC;
         S_ANG:  cmd.op = twcg_pkg::OP_ANG;
         S_NORM: cmd.op = twcg_pkg::OP_NORM;
         S_LOAD: if (status.out_free) cmd.op = twcg_pkg::OP_LOAD;
         S_SEG:  cmd.op = twcg_pkg::OP_SEG;
         S_ACC:  cmd.op = twcg_pkg::OP_ACC;
         default: ;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// File: tb/tb_traveling_wave_curve_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_traveling_wave_curve_generator_unit
// Self-checking bench for the traveling wave curve generator. Ticks go in with
// random advance flags under several register settings; a scoreboard predicts
// every emitted point (position and normal) and checks each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_traveling_wave_curve_generator_unit;

   localparam logic [2:0] IDX_UNUSED = 3'd7;
   localparam longint K_GAIN = 652032874;
   localparam longint ONE_Q30 = 1073741824;
   localparam int ROT_STEPS = twcg_pkg::CORDIC_STEPS_DEF;
   localparam longint ATAN_TURNS [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   typedef struct packed {
      logic [5:0]         idx;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic               fin;
   } point_type;

   class curve_scoreboard;
      bit [6:0]  pt_count;
      bit [19:0] seg_len;
      bit [15:0] ph_step, sp_step, gain;
      bit [15:0] phase, last_angle;
      point_type expected[$];
      int        mismatches;

      function new();
         pt_count = 40; seg_len = 4202; ph_step = 1043; sp_step = 671;
         gain = 3217; phase = 0; last_angle = 0; mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [19:0] d);
         case (idx)
            twcg_pkg::REG_POINT_COUNT:  pt_count = d[6:0];
            twcg_pkg::REG_SEGMENT_LEN:  seg_len = d;
            twcg_pkg::REG_PHASE_STEP:   ph_step = d[15:0];
            twcg_pkg::REG_SPATIAL_STEP: sp_step = d[15:0];
            twcg_pkg::REG_WAVE_GAIN:    gain = d[15:0];
            default: ;
         endcase
      endfunction

      function void rotate(ref longint x, ref longint y, input longint z);
         longint xs, ys;
         for (int k = 0; k < ROT_STEPS; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0) begin
               x -= ys; y += xs; z -= ATAN_TURNS[k];
            end else begin
               x += ys; y -= xs; z += ATAN_TURNS[k];
            end
         end
      endfunction

      function longint arctan(longint y);
         longint x, z, xs, ys;
         x = ONE_Q30;
         z = 0;
         for (int k = 0; k < ROT_STEPS; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
               x += ys; y -= xs; z += ATAN_TURNS[k];
            end else begin
               x -= ys; y += xs; z -= ATAN_TURNS[k];
            end
         end
         return z;
      endfunction

      function longint sine(bit [15:0] p);
         longint x, y, z;
         bit flip;
         x = K_GAIN;
         y = 0;
         flip = (p[15:14] == 2'd1) || (p[15:14] == 2'd2);
         if (flip) z = (longint'(p) - 32768) * 65536;
         else z = longint'($signed(p)) * 65536;
         rotate(x, y, z);
         return flip ? -y : y;
      endfunction

      function longint clamp_q(longint v);
         if (v > 16384) return 16384;
         if (v < -16384) return -16384;
         return v;
      endfunction

      function longint slope_angle(int i);
         bit [15:0] p;
         longint t;
         p = phase - 16'(i * sp_step);
         t = (longint'(gain) * sine(p)) >>> 12;
         return clamp_q((arctan(t) + 32768) >>> 16);
      endfunction

      function void note_tick(bit adv);
         int n;
         longint right, left, nang, x, y;
         bit [31:0] wx, wy;
         point_type pt;
         n = pt_count;
         if (n < 2) n = 2;
         if (n > 64) n = 64;
         if (adv) phase += ph_step;
         wx = 0; wy = 0; right = 0;
         for (int i = 0; i < n; i++) begin
            left = longint'($signed(last_angle));
            if (i + 1 < n) right = slope_angle(i + 1);
            if (i == 0) nang = right * 65536;
            else if (i == n - 1) nang = left * 65536;
            else nang = (left + right) * 32768;
            x = K_GAIN; y = 0;
            rotate(x, y, nang);
            pt.idx = 6'(i);
            pt.x = wx;
            pt.y = wy;
            pt.nx = 16'(-clamp_q((y + 32768) >>> 16));
            pt.ny = 16'(clamp_q((x + 32768) >>> 16));
            pt.fin = (i == n - 1);
            expected.push_back(pt);
            if (i + 1 < n) begin
               x = K_GAIN * longint'(seg_len);
               y = 0;
               rotate(x, y, right * 65536);
               wx += 32'((x + 536870912) >>> 30);
               wy += 32'((y + 536870912) >>> 30);
               last_angle = 16'(right);
            end
         end
      endfunction

      function void check(point_type got);
         point_type want;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected point idx=%0d x=%0d y=%0d", got.idx, got.x, got.y);
            return;
         end
         want = expected.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("point mismatch exp idx=%0d x=%0d y=%0d nx=%0d ny=%0d f=%0b | %s",
                        want.idx, want.x, want.y, want.nx, want.ny, want.fin,
                        $sformatf("got idx=%0d x=%0d y=%0d nx=%0d ny=%0d f=%0b",
                                  got.idx, got.x, got.y, got.nx, got.ny, got.fin));
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [2:0]  csr_index = '0;
   logic [19:0] csr_wr_data = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_advance = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [5:0]  rsp_point_index;
   logic signed [31:0] rsp_pos_x, rsp_pos_y;
   logic signed [15:0] rsp_norm_x, rsp_norm_y;
   logic        rsp_final_point;

   curve_scoreboard curve_sb = new();
   bit   allow_idle = 1;
   int   hold_left = 0;

   traveling_wave_curve_generator_unit DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_advance(req_advance),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_point_index(rsp_point_index), .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y),
      .rsp_final_point(rsp_final_point)
   );

   always #10 clock = ~clock;

   // stall the result side in bursts
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else if (allow_idle && $urandom_range(0, 9) == 0) begin
         hold_left <= $urandom_range(0, 14);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         curve_sb.check('{rsp_point_index, rsp_pos_x, rsp_pos_y,
                          rsp_norm_x, rsp_norm_y, rsp_final_point});
   end

   task automatic send_tick(bit adv);
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1;
      req_advance <= adv;
      do @(posedge clock); while (req_stall);
      curve_sb.note_tick(adv);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (curve_sb.expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [19:0] d);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= d;
      @(posedge clock);
      curve_sb.write_reg(idx, d);
   endtask

   task automatic set_regs(int pc, int len, int ps, int ss, int g);
      csr_write(twcg_pkg::REG_POINT_COUNT, 20'(pc));
      csr_write(twcg_pkg::REG_SEGMENT_LEN, 20'(len));
      csr_write(twcg_pkg::REG_PHASE_STEP, 20'(ps));
      csr_write(twcg_pkg::REG_SPATIAL_STEP, 20'(ss));
      csr_write(twcg_pkg::REG_WAVE_GAIN, 20'(g));
      csr_wr_en <= 0;
   endtask

   task automatic run_ticks(int count);
      for (int i = 0; i < count; i++) send_tick($urandom_range(0, 1));
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults, re-emit and advance
      send_tick(0);
      send_tick(1);
      send_tick(1);
      drain();
      // two points, zero length, zero gain
      set_regs(2, 0, 16'hFFFF, 0, 0);
      send_tick(1);
      send_tick(0);
      drain();
      // full length, widest values, position wrap
      set_regs(64, 20'hFFFFF, 16'h4000, 16'hFFFF, 16'hFFFF);
      send_tick(1);
      send_tick(1);
      drain();
      // over-range and zero point counts, wide writes, unused index
      csr_write(twcg_pkg::REG_POINT_COUNT, 20'hFFFFF);
      csr_write(IDX_UNUSED, 20'hFFFFF);
      csr_write(twcg_pkg::REG_WAVE_GAIN, 20'hF8000);
      csr_wr_en <= 0;
      send_tick(1);
      drain();
      set_regs(0, 20'h10000, 16'h8000, 16'h2000, 16'h1000);
      send_tick(1);
      send_tick(1);
      send_tick(0);
      drain();
      set_regs(1, 20'h00001, 16'h0001, 16'h0001, 16'h0001);
      send_tick(1);
      send_tick(0);
      drain();

      for (int ph = 0; ph < 15; ph++) begin
         int pc;
         case ($urandom_range(0, 9))
            0: pc = 64;
            1: pc = $urandom_range(0, 1);
            2: pc = $urandom_range(65, 127);
            default: pc = $urandom_range(2, 12);
         endcase
         if (ph == 14) allow_idle = 0;
         set_regs(pc, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 16'hFFFF),
                  $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
         run_ticks(12);
      end

      if (curve_sb.mismatches == 0 && curve_sb.expected.size() == 0)
         $display("** traveling_wave_curve_generator_unit: PASSED **");
      else
         $display("** traveling_wave_curve_generator_unit: FAILED **");
      $finish;
   end

   initial begin
      #100ms;
      $display("** traveling_wave_curve_generator_unit: FAILED **");
      $finish;
   end

endmodule
